// File: rtl/mrsi_pkg.sv
// ---------------------------------------------------------------------------
// mrsi_pkg: shared types and constants for the mixed-radix slice index block
// Field widths, register indexes, status and operation codes, item structs.
// ---------------------------------------------------------------------------
package mrsi_pkg;

    localparam int MAX_EXTRA_AXES = 4;
    localparam int EXTENT_BITS    = 12;

    // Extent registers physically present; the axis limit is the smaller one.
    localparam int EXT_REGS   = 4;
    localparam int LIMIT_AXES = (MAX_EXTRA_AXES < EXT_REGS) ? MAX_EXTRA_AXES : EXT_REGS;

    localparam int LIN_W      = 48;
    localparam int AXC_W      = 3;
    localparam int KLEN_W     = 3;
    localparam int REGIDX_W   = 3;
    localparam int CFG_W      = (EXTENT_BITS > AXC_W) ? EXTENT_BITS : AXC_W;
    localparam int EXT_IDX_W  = $clog2(EXT_REGS);
    localparam int PROD_IDX_W = $clog2(EXT_REGS + 1);
    localparam int QBIT_W     = $clog2(EXTENT_BITS);
    localparam int MUL_W      = LIN_W + EXTENT_BITS;
    localparam int DSH_W      = LIN_W + EXTENT_BITS - 1;
    localparam int DSUB_W     = LIN_W + EXTENT_BITS;

    localparam logic [AXC_W-1:0] AXIS_MIN = AXC_W'(2);
    localparam logic [AXC_W-1:0] AXIS_MAX = AXC_W'(2 + LIMIT_AXES);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_AXES = 2'd1,
        ST_KEY_LEN  = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic [REGIDX_W-1:0] {
        REG_AXIS_COUNT = 3'd0,
        REG_EXTENT_A   = 3'd1,
        REG_EXTENT_B   = 3'd2,
        REG_EXTENT_C   = 3'd3,
        REG_EXTENT_D   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                   operation;
        logic [KLEN_W-1:0]      key_length;
        logic [EXTENT_BITS-1:0] coord_a;
        logic [EXTENT_BITS-1:0] coord_b;
        logic [EXTENT_BITS-1:0] coord_c;
        logic [EXTENT_BITS-1:0] coord_d;
        logic [LIN_W-1:0]       slice_number;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [LIN_W-1:0]       linear_result;
        logic [KLEN_W-1:0]      result_length;
        logic [EXTENT_BITS-1:0] out_a;
        logic [EXTENT_BITS-1:0] out_b;
        logic [EXTENT_BITS-1:0] out_c;
        logic [EXTENT_BITS-1:0] out_d;
    } t_out_item;

    typedef struct packed {
        logic [REGIDX_W-1:0] reg_index;
        logic [CFG_W-1:0]    wdata;
    } t_cfg_wr;

endpackage

// File: rtl/mrsi_ifs.sv
// ---------------------------------------------------------------------------
// mrsi channels: valid/ready interfaces for input, result and config items
// Each carries valid, ready and one payload struct from mrsi_pkg.
// ---------------------------------------------------------------------------
interface mrsi_in_if;
    logic               valid;
    logic               ready;
    mrsi_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mrsi_out_if;
    logic                valid;
    logic                ready;
    mrsi_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mrsi_cfg_if;
    logic              valid;
    logic              ready;
    mrsi_pkg::t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mixed_radix_slice_index_top.sv
// ---------------------------------------------------------------------------
// mixed_radix_slice_index_top: slice key <-> linear slice number converter
// Encodes a key of up to four extra-axis coordinates into a linear index, or
// decodes a linear index back into coordinates, with status reporting.
// ---------------------------------------------------------------------------
// Channels: i_in takes one request item (operation, key, slice number);
// o_out returns exactly one result item per request; i_cfg writes the axis
// count (index 0) and extents a..d (indexes 1..4), always ready, and should
// only be used while no request is in flight.
// Sequence of steps after accept:
//   rejected request (bad axis count, key length, decode below 2 axes):
//     result valid in the cycle after accept
//   encode: prefix products of the extents, then a multiply and an add per axis
//   decode: prefix products, range check, per axis a load and the divide steps
// One 48x12 multiplier builds the extent products and the encode terms; one
// 60-bit subtractor runs a restoring divider, one quotient bit per cycle.
// One item at a time: i_in.ready is high only while idle, so a new request
// waits until the result of the last one has been taken.
// The result holds on o_out until taken; a stalled receiver blocks input.
// Reset (synchronous) sets axis_count 2 and all extents 1, and idles.
// ---------------------------------------------------------------------------
module mixed_radix_slice_index_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrsi_in_if.sink    i_in,
    mrsi_out_if.source o_out,
    mrsi_cfg_if.sink   i_cfg
);
    import mrsi_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PROD     = 8'b0000_0010,
        S_ENC_MUL  = 8'b0000_0100,
        S_ENC_ADD  = 8'b0000_1000,
        S_CHECK    = 8'b0001_0000,
        S_DIV_LOAD = 8'b0010_0000,
        S_DIV      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [AXC_W-1:0]                         r_axis;
    logic [EXT_REGS-1:0][EXTENT_BITS-1:0]     r_ext;

    // working registers
    logic                                     r_op, n_op;
    logic [KLEN_W-1:0]                        r_extra, n_extra;
    logic [PROD_IDX_W-1:0]                    r_cnt, n_cnt;
    logic [EXT_REGS-1:0][EXTENT_BITS-1:0]     r_coord, n_coord;
    logic [LIN_W-1:0]                         r_prod [0:EXT_REGS];
    logic [LIN_W-1:0]                         n_prod [0:EXT_REGS];
    logic [LIN_W-1:0]                         r_term, n_term;
    logic [LIN_W-1:0]                         r_rem, n_rem;
    logic [DSH_W-1:0]                         r_dsh, n_dsh;
    logic [EXTENT_BITS-1:0]                   r_q, n_q;
    logic [QBIT_W-1:0]                        r_bit, n_bit;

    // result
    t_status                                  r_status, n_status;
    logic [LIN_W-1:0]                         r_acc, n_acc;
    logic [KLEN_W-1:0]                        r_rlen, n_rlen;
    logic [EXT_REGS-1:0][EXTENT_BITS-1:0]     r_outc, n_outc;

    // shared units
    logic [LIN_W-1:0]       w_mul_a;
    logic [EXTENT_BITS-1:0] w_mul_b;
    logic [MUL_W-1:0]       w_mul_full;
    logic [LIN_W-1:0]       w_mul;
    logic [DSUB_W-1:0]      w_diff;
    logic                   w_ge;
    logic [EXTENT_BITS-1:0] w_qnext;
    logic [EXT_IDX_W-1:0]   w_eidx;

    assign w_eidx     = r_cnt[EXT_IDX_W-1:0];
    assign w_mul_a    = r_prod[r_cnt];
    assign w_mul_b    = (r_state == S_ENC_MUL) ? r_coord[w_eidx] : r_ext[w_eidx];
    assign w_mul_full = MUL_W'(w_mul_a) * MUL_W'(w_mul_b);
    assign w_mul      = w_mul_full[LIN_W-1:0];

    assign w_diff  = DSUB_W'(r_rem) - DSUB_W'(r_dsh);
    assign w_ge    = ~w_diff[DSUB_W-1];
    assign w_qnext = {r_q[EXTENT_BITS-2:0], w_ge};

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = (r_state == S_DONE);

    always_comb begin
        o_out.data.status        = r_status;
        o_out.data.linear_result = r_acc;
        o_out.data.result_length = r_rlen;
        o_out.data.out_a         = r_outc[0];
        o_out.data.out_b         = r_outc[1];
        o_out.data.out_c         = r_outc[2];
        o_out.data.out_d         = r_outc[3];
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_extra  = r_extra;
        n_cnt    = r_cnt;
        n_coord  = r_coord;
        n_prod   = r_prod;
        n_term   = r_term;
        n_rem    = r_rem;
        n_dsh    = r_dsh;
        n_q      = r_q;
        n_bit    = r_bit;
        n_status = r_status;
        n_acc    = r_acc;
        n_rlen   = r_rlen;
        n_outc   = r_outc;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op       = i_in.data.operation;
                    n_extra    = KLEN_W'(r_axis - AXIS_MIN);
                    n_coord[0] = i_in.data.coord_a;
                    n_coord[1] = i_in.data.coord_b;
                    n_coord[2] = i_in.data.coord_c;
                    n_coord[3] = i_in.data.coord_d;
                    n_rem      = i_in.data.slice_number;
                    n_prod[0]  = LIN_W'(1);
                    n_cnt      = '0;
                    n_status   = ST_OK;
                    n_acc      = '0;
                    n_rlen     = '0;
                    n_outc     = '0;
                    if (r_axis > AXIS_MAX) begin
                        n_status = ST_BAD_AXES;
                        n_state  = S_DONE;
                    end else if (r_axis < AXIS_MIN) begin
                        n_status = (i_in.data.operation == OP_ENCODE) ? ST_BAD_AXES : ST_RANGE;
                        n_state  = S_DONE;
                    end else if (i_in.data.operation == OP_ENCODE &&
                                 i_in.data.key_length != KLEN_W'(r_axis - AXIS_MIN)) begin
                        n_status = ST_KEY_LEN;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_PROD;
                    end
                end
            end
            S_PROD: begin
                // build prefix products of the extents up to the extra axis count
                if (KLEN_W'(r_cnt) == r_extra) begin
                    if (r_op == OP_DECODE) begin
                        n_state = S_CHECK;
                    end else if (r_extra == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_ENC_MUL;
                    end
                end else begin
                    n_prod[r_cnt + PROD_IDX_W'(1)] = w_mul;
                    n_cnt = r_cnt + PROD_IDX_W'(1);
                end
            end
            S_ENC_MUL: begin
                n_term  = w_mul;
                n_state = S_ENC_ADD;
            end
            S_ENC_ADD: begin
                n_acc = r_acc + r_term;
                if (KLEN_W'(r_cnt) == r_extra - KLEN_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_cnt + PROD_IDX_W'(1);
                    n_state = S_ENC_MUL;
                end
            end
            S_CHECK: begin
                // r_cnt equals the extra axis count here: r_prod[r_cnt] is the slice count
                if (r_rem >= r_prod[r_cnt]) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else if (r_extra == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_cnt - PROD_IDX_W'(1);
                    n_state = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: begin
                n_dsh   = {r_prod[r_cnt], (EXTENT_BITS-1)'(0)};
                n_q     = '0;
                n_bit   = QBIT_W'(EXTENT_BITS - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_ge) begin
                    n_rem = w_diff[LIN_W-1:0];
                end
                n_q   = w_qnext;
                n_dsh = r_dsh >> 1;
                if (r_bit == '0) begin
                    n_outc[w_eidx] = w_qnext;
                    if (r_cnt == '0) begin
                        n_rlen  = r_extra;
                        n_state = S_DONE;
                    end else begin
                        n_cnt   = r_cnt - PROD_IDX_W'(1);
                        n_state = S_DIV_LOAD;
                    end
                end else begin
                    n_bit = r_bit - QBIT_W'(1);
                end
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_extra  <= n_extra;
        r_cnt    <= n_cnt;
        r_coord  <= n_coord;
        r_prod   <= n_prod;
        r_term   <= n_term;
        r_rem    <= n_rem;
        r_dsh    <= n_dsh;
        r_q      <= n_q;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_acc    <= n_acc;
        r_rlen   <= n_rlen;
        r_outc   <= n_outc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= AXIS_MIN;
            for (int k = 0; k < EXT_REGS; k++) begin
                r_ext[k] <= EXTENT_BITS'(1);
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                REG_AXIS_COUNT: r_axis   <= i_cfg.data.wdata[AXC_W-1:0];
                REG_EXTENT_A:   r_ext[0] <= i_cfg.data.wdata[EXTENT_BITS-1:0];
                REG_EXTENT_B:   r_ext[1] <= i_cfg.data.wdata[EXTENT_BITS-1:0];
                REG_EXTENT_C:   r_ext[2] <= i_cfg.data.wdata[EXTENT_BITS-1:0];
                REG_EXTENT_D:   r_ext[3] <= i_cfg.data.wdata[EXTENT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // an accepted item always starts work or a result
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not leave idle");

    // remainder entering a division step stays below the next-higher prefix product
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_LOAD) |-> (r_rem < r_prod[r_cnt + PROD_IDX_W'(1)]))
        else $error("decode remainder out of range");

    // each decoded coordinate lies below its extent
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit == '0) |-> (w_qnext < r_ext[w_eidx]))
        else $error("decoded coordinate not below extent");

    // encode results carry no coordinates
    a_enc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_op == OP_ENCODE) |-> (r_rlen == '0 && r_outc == '0))
        else $error("encode result has coordinates");

endmodule

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the mixed-radix slice index converter
// Writes the axis count and extents through the config channel, then sends
// encode and decode requests. Each answer is predicted from a local copy of
// the registers and compared field by field with what the block returns.
// Both channel sides idle at random, and one long receiver stall backs up
// the input.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrsi_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrsi_in_if  in_ch ();
    mrsi_out_if res_ch ();
    mrsi_cfg_if cfg_ch ();

    mixed_radix_slice_index_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register copy used for prediction, updated on each accepted write
    logic [AXC_W-1:0]       axes_cfg = AXIS_MIN;
    logic [EXTENT_BITS-1:0] ext_cfg [EXT_REGS] = '{default: 1};

    t_in_item  request_q [$];
    t_cfg_wr   reg_write_q [$];
    t_out_item answer_q [$];

    int n_sent, n_accepted, n_results, n_cfg_sent, n_cfg_done, n_errors;
    bit in_fired, res_fired, cfg_fired;
    bit idle_on = 1'b1;
    bit rx_hold = 1'b0;
    int tx_gap, rx_stall;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LIN_W-1:0] rand_lin();
        return LIN_W'({$urandom, $urandom});
    endfunction

    // number of slices under the current register copy
    function automatic logic [63:0] slice_total();
        logic [63:0] prod;
        if (axes_cfg < AXIS_MIN || axes_cfg > AXIS_MAX) return 64'd0;
        prod = 64'd1;
        for (int i = 0; i < int'(axes_cfg) - 2; i++) prod *= ext_cfg[i];
        return prod;
    endfunction

    function automatic t_out_item convert_slice_index(t_in_item it);
        t_out_item              res;
        logic [EXTENT_BITS-1:0] key [EXT_REGS];
        logic [EXTENT_BITS-1:0] coord [EXT_REGS];
        logic [63:0]            acc, weight, rest, lower, q;
        int                     extra;
        res = '0;
        res.status = ST_OK;
        key[0] = it.coord_a;
        key[1] = it.coord_b;
        key[2] = it.coord_c;
        key[3] = it.coord_d;
        coord = '{default: '0};
        if (axes_cfg > AXIS_MAX) begin
            res.status = ST_BAD_AXES;
            return res;
        end
        extra = int'(axes_cfg) - 2;
        if (t_op'(it.operation) == OP_ENCODE) begin
            if (axes_cfg < AXIS_MIN) begin
                res.status = ST_BAD_AXES;
                return res;
            end
            if (int'(it.key_length) != extra) begin
                res.status = ST_KEY_LEN;
                return res;
            end
            acc = 64'd0;
            weight = 64'd1;
            for (int i = 0; i < extra; i++) begin
                acc += weight * key[i];
                weight *= ext_cfg[i];
            end
            res.linear_result = acc[LIN_W-1:0];
        end else begin
            rest = 64'(it.slice_number);
            if (rest >= slice_total()) begin
                res.status = ST_RANGE;
                return res;
            end
            // peel coordinates from the slowest axis down
            for (int i = extra - 1; i >= 0; i--) begin
                lower = 64'd1;
                for (int j = 0; j < i; j++) lower *= ext_cfg[j];
                q = (lower == 0) ? 64'd0 : rest / lower;
                rest -= q * lower;
                coord[i] = q[EXTENT_BITS-1:0];
            end
            res.result_length = KLEN_W'(extra);
            res.out_a = coord[0];
            res.out_b = coord[1];
            res.out_c = coord[2];
            res.out_d = coord[3];
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // -------------------------------------------------------------------
    // drivers: change at the falling edge
    // -------------------------------------------------------------------
    always @(negedge i_clk) begin : request_drive
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = in_ch.valid;
        nxt_data  = in_ch.data;
        if (in_fired) nxt_valid = 1'b0;
        if (!nxt_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (request_q.size() > 0) begin
                nxt_data  = request_q.pop_front();
                nxt_valid = 1'b1;
                tx_gap    = idle_on ? gap_len() : 0;
            end
        end
        in_ch.valid <= nxt_valid;
        in_ch.data  <= nxt_data;
    end

    always @(negedge i_clk) begin : answer_drive
        if (res_fired) rx_stall = idle_on ? gap_len() : 0;
        if (rx_hold) begin
            res_ch.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin : reg_write_drive
        logic    nxt_valid;
        t_cfg_wr nxt_data;
        nxt_valid = cfg_ch.valid;
        nxt_data  = cfg_ch.data;
        if (cfg_fired) nxt_valid = 1'b0;
        if (!nxt_valid && reg_write_q.size() > 0) begin
            nxt_data  = reg_write_q.pop_front();
            nxt_valid = 1'b1;
        end
        cfg_ch.valid <= nxt_valid;
        cfg_ch.data  <= nxt_data;
    end

    // -------------------------------------------------------------------
    // monitor: sample at the rising edge
    // -------------------------------------------------------------------
    always @(posedge i_clk) begin : channel_monitor
        t_out_item want, got;
        in_fired  = 1'b0;
        res_fired = 1'b0;
        cfg_fired = 1'b0;
        if (!i_rst_n) begin
            axes_cfg = AXIS_MIN;
            ext_cfg  = '{default: 1};
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                cfg_fired = 1'b1;
                n_cfg_done++;
                case (t_reg_idx'(cfg_ch.data.reg_index))
                    REG_AXIS_COUNT: axes_cfg   = cfg_ch.data.wdata[AXC_W-1:0];
                    REG_EXTENT_A:   ext_cfg[0] = cfg_ch.data.wdata[EXTENT_BITS-1:0];
                    REG_EXTENT_B:   ext_cfg[1] = cfg_ch.data.wdata[EXTENT_BITS-1:0];
                    REG_EXTENT_C:   ext_cfg[2] = cfg_ch.data.wdata[EXTENT_BITS-1:0];
                    REG_EXTENT_D:   ext_cfg[3] = cfg_ch.data.wdata[EXTENT_BITS-1:0];
                    default: ;  // unmapped index: drop
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                in_fired = 1'b1;
                n_accepted++;
                answer_q.push_back(convert_slice_index(in_ch.data));
            end
            if (res_ch.valid && res_ch.ready) begin
                res_fired = 1'b1;
                n_results++;
                got = res_ch.data;
                if (answer_q.size() == 0) begin
                    $error("result item with no request outstanding");
                    n_errors++;
                end else begin
                    want = answer_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("linear_result", want.linear_result, got.linear_result);
                    check_field("result_length", want.result_length, got.result_length);
                    check_field("out_a", want.out_a, got.out_a);
                    check_field("out_b", want.out_b, got.out_b);
                    check_field("out_c", want.out_c, got.out_c);
                    check_field("out_d", want.out_d, got.out_d);
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // stimulus
    // -------------------------------------------------------------------
    task automatic write_reg(logic [REGIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_cfg_wr w;
        w.reg_index = idx;
        w.wdata     = val;
        reg_write_q.push_back(w);
        n_cfg_sent++;
    endtask

    task automatic queue_request(t_op op, logic [KLEN_W-1:0] klen,
                                 logic [EXTENT_BITS-1:0] a, logic [EXTENT_BITS-1:0] b,
                                 logic [EXTENT_BITS-1:0] c, logic [EXTENT_BITS-1:0] d,
                                 logic [LIN_W-1:0] slice);
        t_in_item it;
        it.operation    = op;
        it.key_length   = klen;
        it.coord_a      = a;
        it.coord_b      = b;
        it.coord_c      = c;
        it.coord_d      = d;
        it.slice_number = slice;
        request_q.push_back(it);
        n_sent++;
    endtask

    // wait until every write has landed and every answer has come back
    task automatic drain();
        wait (n_cfg_done == n_cfg_sent && n_results == n_sent);
        @(negedge i_clk);
    endtask

    task automatic set_axes_extents(logic [AXC_W-1:0] axes, logic [EXTENT_BITS-1:0] ea,
                                    logic [EXTENT_BITS-1:0] eb, logic [EXTENT_BITS-1:0] ec,
                                    logic [EXTENT_BITS-1:0] ed);
        drain();
        // junk in the upper bits of the axis count write must be dropped
        write_reg(REG_AXIS_COUNT, {9'($urandom), axes});
        write_reg(REG_EXTENT_A, ea);
        write_reg(REG_EXTENT_B, eb);
        write_reg(REG_EXTENT_C, ec);
        write_reg(REG_EXTENT_D, ed);
        drain();
    endtask

    function automatic logic [EXTENT_BITS-1:0] pick_extent();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 6)  return EXTENT_BITS'($urandom);
        return EXTENT_BITS'($urandom_range(1, 12));
    endfunction

    function automatic logic [EXTENT_BITS-1:0] pick_coord(int axis);
        if (ext_cfg[axis] != 0 && $urandom_range(0, 7) != 0)
            return EXTENT_BITS'($urandom_range(0, ext_cfg[axis] - 1));
        return EXTENT_BITS'($urandom);
    endfunction

    initial begin : stimulus
        logic [AXC_W-1:0]  axes;
        logic [KLEN_W-1:0] klen;
        logic [63:0]       total;
        logic [LIN_W-1:0]  slice;
        int                r, n_random, n_phase;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: two axes, a single slice
        queue_request(OP_ENCODE, 3'd0, '1, '1, '1, '1, '1);
        queue_request(OP_ENCODE, 3'd1, '0, '0, '0, '0, '0);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '0);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, 48'd1);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '1);

        // all four extra axes at full extent
        set_axes_extents(AXIS_MAX, '1, '1, '1, '1);
        queue_request(OP_ENCODE, 3'd4, '1, '1, '1, '1, '0);
        queue_request(OP_ENCODE, 3'd3, '1, '1, '1, '1, '0);
        queue_request(OP_ENCODE, 3'd4, '0, '0, '0, '0, '1);
        queue_request(OP_DECODE, 3'd4, '1, '1, '1, '1, LIN_W'(slice_total() - 1));
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, LIN_W'(slice_total()));
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '1);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '0);

        // axis count above the cap
        set_axes_extents(AXIS_MAX + 3'd1, 12'd3, 12'd3, 12'd3, 12'd3);
        queue_request(OP_ENCODE, 3'd4, 12'd1, 12'd1, 12'd1, 12'd1, '0);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '0);

        // fewer than two axes
        set_axes_extents(3'd0, 12'd3, 12'd3, 12'd3, 12'd3);
        queue_request(OP_ENCODE, 3'd0, '0, '0, '0, '0, '0);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '0);
        set_axes_extents(3'd1, 12'd3, 12'd3, 12'd3, 12'd3);
        queue_request(OP_ENCODE, 3'd0, '0, '0, '0, '0, '0);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '0);

        // zero extent: decode always out of range, encode still multiplies
        set_axes_extents(3'd4, 12'd0, 12'd5, 12'd7, 12'd9);
        write_reg(3'(REG_EXTENT_D + 1), '1);
        write_reg(3'(REG_EXTENT_D + 3), '1);
        drain();
        queue_request(OP_ENCODE, 3'd2, 12'd7, 12'd3, '0, '0, '0);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, '0);

        // key values past the extent are taken as they are
        set_axes_extents(3'd3, 12'd10, 12'd2, 12'd2, 12'd2);
        queue_request(OP_ENCODE, 3'd1, '1, '0, '0, '0, '0);
        queue_request(OP_DECODE, 3'd0, '0, '0, '0, '0, 48'd9);

        n_random = 0;
        while (n_random < 1300) begin
            r = $urandom_range(0, 9);
            if (r == 0)      axes = AXIS_MAX + 3'd1;
            else if (r == 1) axes = AXC_W'($urandom_range(0, 1));
            else             axes = AXC_W'($urandom_range(2, 2 + LIMIT_AXES));
            set_axes_extents(axes, pick_extent(), pick_extent(), pick_extent(), pick_extent());
            if ($urandom_range(0, 4) == 0) begin
                write_reg(3'(REG_EXTENT_D + $urandom_range(1, 3)), CFG_W'($urandom));
                drain();
            end
            idle_on = ($urandom_range(0, 3) != 0);
            total = slice_total();
            n_phase = $urandom_range(30, 70);
            for (int k = 0; k < n_phase; k++) begin
                if ($urandom_range(0, 1) == 0) begin
                    if (axes >= AXIS_MIN && axes <= AXIS_MAX && $urandom_range(0, 7) != 0)
                        klen = KLEN_W'(axes - AXIS_MIN);
                    else
                        klen = KLEN_W'($urandom_range(0, 4));
                    queue_request(OP_ENCODE, klen, pick_coord(0), pick_coord(1),
                                  pick_coord(2), pick_coord(3), rand_lin());
                end else begin
                    r = $urandom_range(0, 9);
                    if (total == 0 || r == 0) slice = rand_lin();
                    else if (r == 1)          slice = LIN_W'(total);
                    else if (r == 2)          slice = LIN_W'(total - 1);
                    else                      slice = LIN_W'({$urandom, $urandom} % total);
                    queue_request(OP_DECODE, KLEN_W'($urandom_range(0, 4)),
                                  EXTENT_BITS'($urandom), EXTENT_BITS'($urandom),
                                  EXTENT_BITS'($urandom), EXTENT_BITS'($urandom), slice);
                end
            end
            n_random += n_phase;
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            $error("%0d answers never arrived", answer_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hold the receiver off for a long stretch while requests keep coming
    initial begin : rx_hold_off
        wait (n_accepted >= 200 && request_q.size() > 10);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : watchdog
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/mrsi_pkg.sv
rtl/mrsi_ifs.sv
rtl/mixed_radix_slice_index_top.sv
test/tb_top.sv
